### design/tac_pkg.sv
// Shared types, constants and widths for the thermistor averaging block.
// No dependencies.
`default_nettype none
package tac_pkg;
  localparam int NUM_CHANNELS_DEF = 5;
  localparam int SAMPLES_PER_CHANNEL_DEF = 10;
  localparam int SUM_W = 16;
  localparam int ADC_W = 12;
  localparam int TEMP_W = 15;
  localparam int CH_W = 3;
  localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] INV_T0_Q40 = ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;
  localparam logic signed [TEMP_W-1:0] T_LOW = -15'sd4370;
  localparam logic signed [TEMP_W-1:0] T_HIGH = 15'sd12000;
  localparam logic [1:0] REG_SERIES = 2'd0;
  localparam logic [1:0] REG_NOMINAL = 2'd1;
  localparam logic [1:0] REG_BETA = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [ADC_W-1:0] avg;
    logic             last;
  } job_t;
endpackage
`default_nettype wire

### design/tac_front.sv
// Front part: accumulates per-channel sums and emits one job per channel per frame.
// Depends on tac_pkg.
`default_nettype none
module tac_front import tac_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ADC_W-1:0] sample,
  input  wire logic             frame_start,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output job_t                  job
);
  localparam int FRAME_LEN = NUM_CHANNELS * SAMPLES_PER_CHANNEL;
  localparam int POS_W = $clog2(FRAME_LEN + 1);
  localparam int CI_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RECIP_SH = 20;
  localparam logic [20:0] AVG_RECIP =
    21'(((1 << RECIP_SH) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL);

  logic [SUM_W-1:0] sums_r [NUM_CHANNELS];
  logic [POS_W-1:0] pos_r;
  logic [CI_W-1:0]  ch_r;
  logic             emit_r;
  logic [CI_W-1:0]  ech_r;
  logic [SUM_W-1:0] cur_sum;
  logic [36:0]      avg_prod;
  logic [SUM_W-1:0] avg_full;

  assign in_ready = !emit_r;
  // divide by the sample count through a reciprocal multiply
  assign avg_prod = sums_r[ech_r] * AVG_RECIP;
  assign avg_full = avg_prod[RECIP_SH +: SUM_W];
  assign cur_sum = frame_start ? '0 : sums_r[ch_r];
  assign job_valid = emit_r;
  always_comb begin
    job.ch = CH_W'(ech_r);
    job.avg = avg_full[ADC_W-1:0];
    job.last = (ech_r == CI_W'(NUM_CHANNELS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ch_r <= '0;
      emit_r <= 1'b0;
      ech_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) sums_r[i] <= '0;
    end else if (emit_r) begin
      if (job_ready) begin
        if (ech_r == CI_W'(NUM_CHANNELS - 1)) begin
          emit_r <= 1'b0;
          for (int i = 0; i < NUM_CHANNELS; i++) sums_r[i] <= '0;
        end
        ech_r <= ech_r + 1'b1;
      end
    end else if (in_valid) begin
      if (frame_start) begin
        for (int i = 0; i < NUM_CHANNELS; i++) sums_r[i] <= (i == 0) ? SUM_W'(sample) : '0;
        ch_r <= (NUM_CHANNELS == 1) ? '0 : CI_W'(1);
        pos_r <= (FRAME_LEN == 1) ? '0 : POS_W'(1);
        emit_r <= (FRAME_LEN == 1);
        ech_r <= '0;
      end else begin
        sums_r[ch_r] <= cur_sum + SUM_W'(sample);
        ch_r <= (ch_r == CI_W'(NUM_CHANNELS - 1)) ? '0 : ch_r + 1'b1;
        if (pos_r == POS_W'(FRAME_LEN - 1)) begin
          emit_r <= 1'b1;
          ech_r <= '0;
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/tac_fifo.sv
// Short job queue between front and back parts.
// Depends on tac_pkg.
`default_nettype none
module tac_fifo import tac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_data
);
  job_t        mem_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic        wr, rd;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd4 && !rd) |=> cnt_r == 3'd4) else $error("full queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 && !wr) |=> cnt_r == 3'd0) else $error("empty queue gained entry");
endmodule
`default_nettype wire

### design/tac_back.sv
// Back part: sequenced beta-equation conversion with iterative log and dividers.
// Depends on tac_pkg.
`default_nettype none
module tac_back import tac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [19:0]        series_ohms,
  input  wire logic [19:0]        nominal_ohms,
  input  wire logic [15:0]        beta_kelvin,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  job_t                    job,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [CH_W-1:0]         res_ch,
  output logic signed [TEMP_W-1:0] res_temp,
  output logic                    res_fault,
  output logic                    res_last
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_MUL  = 10'b0000000010, S_NORM = 10'b0000000100,
    S_SQ   = 10'b0000001000, S_LN   = 10'b0000010000, S_DIVY = 10'b0000100000,
    S_X    = 10'b0001000000, S_DIVS = 10'b0010000000, S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t      st_r;
  job_t        job_r;
  logic [31:0] num_r, den_r;
  logic        side_r;
  logic [5:0]  e_r;
  logic [31:0] m_r;
  logic [23:0] f_r;
  logic [4:0]  it_r;
  logic [29:0] lnum_r;
  logic [29:0] mag_r;
  logic        neg_r;
  logic [63:0] div_rem_r, div_den_r, div_q_r;
  logic [6:0]  dcnt_r;
  logic [5:0]  msb;
  logic [63:0] sq;
  logic [31:0] cur;
  logic [29:0] lfull;
  logic [59:0] lnprod;
  logic signed [47:0] x_s;
  logic [64:0] trial;
  logic [20:0] t_u;
  logic [42:0] qprod;
  logic signed [15:0] r_s;
  logic        early;

  assign cur = side_r ? den_r : num_r;
  assign sq = {32'b0, m_r} * {32'b0, m_r};
  assign lfull = {e_r, f_r};
  assign trial = {div_rem_r[63:0], div_q_r[63]} - {1'b0, div_den_r};
  assign lnprod = 60'(mag_r) * 60'(LN2_Q30[29:0]);
  assign x_s = neg_r ? $signed({1'b0, INV_T0_Q40[46:0]}) - $signed({1'b0, div_q_r[46:0]})
                     : $signed({1'b0, INV_T0_Q40[46:0]}) + $signed({1'b0, div_q_r[46:0]});
  // divide by 100 through a reciprocal multiply, exact below 2^21
  assign t_u = div_q_r[20:0] + 21'd63010;
  assign qprod = t_u * 22'd2684355;
  assign r_s = $signed({1'b0, qprod[42:28]}) - 16'sd5000;
  assign early = (job_r.avg == '0) || (job_r.avg == ADC_FULL) || (series_ohms == '0)
                 || (nominal_ohms == '0) || (beta_kelvin == '0);
  assign job_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_ch = job_r.ch;
  assign res_last = job_r.last;
  assign res_fault = (job_r.avg == '0) || (job_r.avg == ADC_FULL);

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) if (cur[i]) msb = 6'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          job_r <= job;
          st_r <= S_MUL;
        end
        S_MUL: begin
          num_r <= 32'(series_ohms) * 32'(ADC_FULL - job_r.avg);
          den_r <= 32'(job_r.avg) * 32'(nominal_ohms);
          side_r <= 1'b0;
          res_temp <= T_LOW;
          st_r <= early ? S_OUT : S_NORM;
        end
        S_NORM: begin
          e_r <= msb;
          m_r <= (msb <= 6'd30) ? (cur << (6'd30 - msb)) : (cur >> (msb - 6'd30));
          f_r <= '0;
          it_r <= '0;
          st_r <= S_SQ;
        end
        S_SQ: begin
          if (sq[61]) begin
            m_r <= 32'(sq[63:31]);
            f_r <= {f_r[22:0], 1'b1};
          end else begin
            m_r <= sq[61:30];
            f_r <= {f_r[22:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == 5'd23) st_r <= S_LN;
        end
        S_LN: if (!side_r) begin
          lnum_r <= lfull;
          side_r <= 1'b1;
          st_r <= S_NORM;
        end else begin
          neg_r <= lnum_r < lfull;
          mag_r <= (lnum_r < lfull) ? lfull - lnum_r : lnum_r - lfull;
          st_r <= S_DIVY;
          dcnt_r <= '0;
        end
        S_DIVY: begin
          if (dcnt_r == 7'd0) begin
            div_q_r <= {lnprod[59:30], 34'b0};
            div_rem_r <= '0;
            div_den_r <= 64'(beta_kelvin);
            dcnt_r <= 7'd1;
          end else begin
            if (!trial[64]) begin
              div_rem_r <= trial[63:0];
              div_q_r <= {div_q_r[62:0], 1'b1};
            end else begin
              div_rem_r <= {div_rem_r[62:0], div_q_r[63]};
              div_q_r <= {div_q_r[62:0], 1'b0};
            end
            dcnt_r <= dcnt_r + 1'b1;
            if (dcnt_r == 7'd46) st_r <= S_X;
          end
        end
        S_X: begin
          if (x_s <= 0) begin
            res_temp <= T_LOW;
            st_r <= S_OUT;
          end else begin
            div_q_r <= (64'd100 << 44);
            div_rem_r <= '0;
            div_den_r <= {16'b0, x_s};
            dcnt_r <= '0;
            st_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (!trial[64]) begin
            div_rem_r <= trial[63:0];
            div_q_r <= {div_q_r[62:0], 1'b1};
          end else begin
            div_rem_r <= {div_rem_r[62:0], div_q_r[63]};
            div_q_r <= {div_q_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 7'd63) st_r <= S_FIN;
        end
        S_FIN: begin
          if (div_q_r >= 64'd1637040) begin
            res_temp <= T_HIGH;
          end else if (r_s < T_LOW) begin
            res_temp <= T_LOW;
          end else begin
            res_temp <= r_s[TEMP_W-1:0];
          end
          st_r <= S_OUT;
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid && $stable(res_temp)) else $error("result dropped");
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_fault) |-> res_temp == T_LOW) else $error("fault without low temp");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_temp >= T_LOW && res_temp <= T_HIGH)) else $error("temp out of range");
endmodule
`default_nettype wire

### design/thermistor_average_to_celsius_top.sv
// Thermistor averager top: front accumulator, job queue, back converter.
// Depends on tac_pkg, tac_front, tac_fifo, tac_back.
//
// Usage: in_tdata carries one 12-bit ADC sample, in_tuser the frame_start flag.
// Samples interleave channel-fast over NUM_CHANNELS channels; after
// NUM_CHANNELS*SAMPLES_PER_CHANNEL samples the front pushes one job per channel
// into a four-deep queue, one per cycle while the queue has room, holding
// in_tready low meanwhile. The back converts one job at a time on the shared
// serial divider and squaring unit: two 24-step log iterations, then a 46-step
// and a 64-step restoring division. The front takes one sample per cycle while
// it is not emitting jobs; the next frame accumulates while the back works.
// out_tdata: channel_index, temperature_sixteenths, sensor_fault; out_tlast
// marks the last channel. A stalled receiver holds the back in its output
// state; the queue then fills and the front stops taking samples.
// Reset (rst_n low, synchronous) clears sums, position, queue and sequencer;
// registers return to 10000 ohm, 10000 ohm, 3500 K.
`default_nettype none
module thermistor_average_to_celsius_top import tac_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] adc_sample
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] channel_index, [17:3] temp, [18] fault
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);
  logic [19:0] series_r, nominal_r;
  logic [15:0] beta_r;
  logic        jv, jr, qv, qr;
  job_t        jd, qd;
  logic [CH_W-1:0] rch;
  logic signed [TEMP_W-1:0] rtemp;
  logic        rfault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= 20'd10000;
      nominal_r <= 20'd10000;
      beta_r <= 16'd3500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SERIES:  series_r <= cfg_wdata;
        REG_NOMINAL: nominal_r <= cfg_wdata;
        REG_BETA:    beta_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  tac_front #(.NUM_CHANNELS(NUM_CHANNELS), .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .sample(in_tdata[11:0]),
    .frame_start(in_tuser), .job_valid(jv), .job_ready(jr), .job(jd));
  tac_fifo u_fifo (.clk, .rst_n, .wr_valid(jv), .wr_ready(jr), .wr_data(jd),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qd));
  tac_back u_back (.clk, .rst_n, .series_ohms(series_r), .nominal_ohms(nominal_r),
    .beta_kelvin(beta_r), .job_valid(qv), .job_ready(qr), .job(qd),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_ch(rch), .res_temp(rtemp),
    .res_fault(rfault), .res_last(out_tlast));

  assign out_tdata = {5'b0, rfault, rtemp, rch};
endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for thermistor_average_to_celsius_top: drives ADC frames,
// predicts each channel's beta-equation temperature and checks every result word.
// Depends on tac_pkg and the RTL of the averager.
`timescale 1ns / 100ps
module testbench;
  import tac_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int FRAME_WORDS = NUM_CHANNELS_DEF * SAMPLES_PER_CHANNEL_DEF;
  localparam int DRAIN_CYCLES = 1200;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [CH_W-1:0]          ch;
    logic signed [TEMP_W-1:0] temp;
    logic                     fault;
    logic                     last;
  } temp_word_t;

  class thermo_scoreboard;
    logic [19:0]      series_r, nominal_r;
    logic [15:0]      beta_r;
    logic [SUM_W-1:0] sums[NCH];
    int               pos;
    temp_word_t       pending_temps[$];
    int               errors;

    function void reset_state();
      series_r = 20'd10000;
      nominal_r = 20'd10000;
      beta_r = 16'd3500;
      foreach (sums[i]) sums[i] = '0;
      pos = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        REG_SERIES:  series_r = val;
        REG_NOMINAL: nominal_r = val;
        REG_BETA:    beta_r = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] log2_q24(logic [63:0] n);
      int unsigned e;
      logic [63:0] t, m, f;
      e = 0;
      t = n;
      f = 0;
      while (t > 1) begin
        t = t >> 1;
        e++;
      end
      m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        f = f << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          f[0] = 1'b1;
        end
      end
      return (64'(e) << 24) | f;
    endfunction

    function void to_celsius(int unsigned avg, output logic signed [TEMP_W-1:0] temp,
                             output logic fault);
      logic [63:0] lnum, lden, mag, y, s;
      longint x, t, r;
      bit neg;
      fault = 1'b0;
      temp = T_LOW;
      if (avg == 0 || avg >= 4095) begin
        fault = 1'b1;
        return;
      end
      if (series_r == 0 || nominal_r == 0 || beta_r == 0) return;
      lnum = log2_q24(64'(series_r) * 64'(4095 - avg));
      lden = log2_q24(64'(avg) * 64'(nominal_r));
      neg = lnum < lden;
      mag = neg ? lden - lnum : lnum - lden;
      mag = (mag * LN2_Q30) >> 30;
      y = (mag << 16) / 64'(beta_r);
      x = neg ? longint'(INV_T0_Q40) - longint'(y) : longint'(INV_T0_Q40) + longint'(y);
      if (x <= 0) return;
      s = ((64'd1 << 44) * 64'd100) / 64'(x);
      if (s >= 64'd1637040) begin
        temp = T_HIGH;
        return;
      end
      t = longint'(s) - 437040;
      r = (t + 50 + 500000) / 100 - 5000;
      if (r < -4370) r = -4370;
      if (r > 12000) r = 12000;
      temp = TEMP_W'(r);
    endfunction

    function void note_sample(logic [ADC_W-1:0] sample, logic frame_start);
      int ch;
      temp_word_t w;
      if (frame_start) begin
        foreach (sums[i]) sums[i] = '0;
        pos = 0;
      end
      if (pos >= FRAME_WORDS) pos = 0;
      ch = pos % NCH;
      sums[ch] = sums[ch] + SUM_W'(sample);
      pos++;
      if (pos < FRAME_WORDS) return;
      for (int k = 0; k < NCH; k++) begin
        w.ch = CH_W'(k);
        to_celsius(sums[k] / SAMPLES_PER_CHANNEL_DEF, w.temp, w.fault);
        w.last = (k == NCH - 1);
        pending_temps.push_back(w);
      end
      foreach (sums[i]) sums[i] = '0;
      pos = 0;
    endfunction

    function void check_result(logic [23:0] data, logic last);
      temp_word_t w;
      if (pending_temps.size() == 0) begin
        $error("unexpected result word %h", data);
        errors++;
        return;
      end
      w = pending_temps.pop_front();
      if (data[2:0] !== w.ch) begin
        $error("channel_index: expected %0d, got %0d", w.ch, data[2:0]);
        errors++;
      end
      if ($signed(data[17:3]) !== w.temp) begin
        $error("temperature_sixteenths: expected %0d, got %0d", w.temp, $signed(data[17:3]));
        errors++;
      end
      if (data[18] !== w.fault) begin
        $error("sensor_fault: expected %0d, got %0d", w.fault, data[18]);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_of_frame: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [11:0] adc_sample
  logic        in_tuser;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [2:0] channel_index, [17:3] temp, [18] fault
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_wdata;

  thermo_scoreboard sb;
  bit  no_gaps;
  int  hold_request;
  int  idle_cycles;
  bit  done;

  thermistor_average_to_celsius_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor both channels and the watchdog counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata[11:0], in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random backpressure, with a long hold on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [ADC_W-1:0] sample, logic frame_start);
    int gap;
    gap = no_gaps ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, sample};
    in_tuser <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // levels holds one center per channel; jitter spreads samples around it
  task automatic send_frame(int levels[NCH], int jitter, int words);
    int v;
    for (int p = 0; p < words; p++) begin
      v = levels[p % NCH] + $urandom_range(0, 2 * jitter) - jitter;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_word(ADC_W'(v), p == 0);
    end
  endtask

  task automatic pick_levels(output int levels[NCH]);
    foreach (levels[i])
      levels[i] = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? 4095 : 0)
                                              : $urandom_range(0, 4095);
  endtask

  task automatic send_random_frames(int count);
    int levels[NCH];
    for (int f = 0; f < count; f++) begin
      pick_levels(levels);
      if ($urandom_range(0, 7) == 0) begin
        // broken frame: restart partway through
        send_frame(levels, 2048, $urandom_range(1, FRAME_WORDS - 1));
      end else begin
        send_frame(levels, $urandom_range(0, 1) ? 0 : $urandom_range(1, 300), FRAME_WORDS);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [19:0] series, logic [19:0] nominal, logic [15:0] beta);
    write_reg(REG_SERIES, series);
    write_reg(REG_NOMINAL, nominal);
    write_reg(REG_BETA, {4'b0, beta});
  endtask

  initial begin
    int levels[NCH];
    sb = new();
    sb.reset_state();
    sb.errors = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    hold_request = 0;
    idle_cycles = 0;
    done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes per channel at reset values, then a restart partway in
    levels = '{0, 4095, 1, 4094, 2048};
    send_frame(levels, 0, FRAME_WORDS);
    levels = '{100, 200, 300, 400, 500};
    send_frame(levels, 0, 12);
    levels = '{4000, 3000, 1500, 700, 50};
    send_frame(levels, 0, FRAME_WORDS);
    drain();

    set_regs(20'd1000000, 20'd1, 16'd1);
    levels = '{1, 2048, 4094, 10, 4000};
    send_frame(levels, 0, FRAME_WORDS);
    drain();
    set_regs(20'd1, 20'd1000000, 16'd65535);
    send_frame(levels, 0, FRAME_WORDS);
    drain();
    set_regs(20'd0, 20'd1000000, 16'd0);
    write_reg(2'd3, 20'hFFFFF);
    send_frame(levels, 0, FRAME_WORDS);
    drain();
    set_regs(20'd10000, 20'd0, 16'd3500);
    send_frame(levels, 0, FRAME_WORDS);
    drain();

    set_regs(20'd10000, 20'd10000, 16'd3500);
    no_gaps = 1'b1;
    send_random_frames(1);
    no_gaps = 1'b0;
    // hold the receiver while three full frames are offered
    hold_request = 3000;
    for (int f = 0; f < 3; f++) begin
      pick_levels(levels);
      send_frame(levels, 100, FRAME_WORDS);
    end
    drain();

    set_regs(20'($urandom_range(1, 1000000)), 20'($urandom_range(1, 1000000)),
             16'($urandom_range(1, 65535)));
    send_random_frames(1);
    drain();
    done = 1'b1;
  end

  initial begin
    @(posedge clk);
    while (!done && idle_cycles < STALL_LIMIT) @(posedge clk);
    if (done && sb.errors == 0 && sb.pending_temps.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
